>>> rtl/rsc_pkg.sv
package rsc_pkg;

    localparam int VALUE_W         = 64;
    localparam int MAX_DIGITS_DEF  = 64;
    localparam int BASE_W          = 5;
    localparam int DIGIT_W         = 4;
    localparam int CFG_IDX_W       = 4;
    localparam int NIBBLES         = VALUE_W / DIGIT_W;
    localparam int NIB_CNT_W       = $clog2(NIBBLES);
    localparam int BIT_CNT_W       = $clog2(VALUE_W);

    localparam logic [BASE_W-1:0] IN_BASE_RST  = 5'd10;
    localparam logic [BASE_W-1:0] OUT_BASE_RST = 5'd16;
    localparam logic [BASE_W-1:0] BASE_MIN     = 5'd2;
    localparam logic [BASE_W-1:0] BASE_MAX     = 5'd16;

    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [7:0] ASCII_NINE = 8'h39;
    localparam logic [7:0] ASCII_A    = 8'h41;
    localparam logic [7:0] ASCII_F    = 8'h46;
    localparam logic [4:0] DIGIT_TEN  = 5'd10;
    localparam logic [4:0] DIGIT_BAD  = 5'd16;

    localparam logic [CFG_IDX_W-1:0] REG_IN_BASE  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_BASE = 4'd1;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_in;
    } char_req_t;

    typedef struct packed {
        logic [7:0] digit_char;
        logic       last_out;
        logic       overflow;
        logic       bad_char;
    } digit_req_t;

    typedef struct packed {
        logic               start;
        logic               clear;
        logic [DIGIT_W-1:0] digit;
    } acc_cmd_t;

    typedef struct packed {
        logic done;
        logic ovf;
    } acc_stat_t;

    typedef struct packed {
        logic start;
        logic reload;
    } div_cmd_t;

    typedef struct packed {
        logic               done;
        logic               nonzero;
        logic [DIGIT_W-1:0] rem;
    } div_stat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACCUM,
        ST_DIVIDE,
        ST_EMIT_RD,
        ST_EMIT_LOAD,
        ST_EMIT_HOLD
    } state_t;

    function automatic logic [BASE_W-1:0] clamp_base(input logic [BASE_W-1:0] b);
        logic [BASE_W-1:0] r;
        r = b;
        if (b < BASE_MIN) r = BASE_MIN;
        else if (b > BASE_MAX) r = BASE_MAX;
        return r;
    endfunction

    // Digit value 0 to 15, or 16 for a character outside 0-9 and A-F.
    function automatic logic [4:0] char_value(input logic [7:0] c);
        logic [7:0] d;
        logic [4:0] r;
        r = DIGIT_BAD;
        if (c >= ASCII_ZERO && c <= ASCII_NINE) begin
            d = c - ASCII_ZERO;
            r = d[4:0];
        end else if (c >= ASCII_A && c <= ASCII_F) begin
            d = c - ASCII_A;
            r = d[4:0] + DIGIT_TEN;
        end
        return r;
    endfunction

    function automatic logic [7:0] digit_ascii(input logic [DIGIT_W-1:0] d);
        logic [7:0] r;
        if (d < DIGIT_TEN[DIGIT_W-1:0]) r = ASCII_ZERO + {4'd0, d};
        else r = ASCII_A + {4'd0, d - DIGIT_TEN[DIGIT_W-1:0]};
        return r;
    endfunction

endpackage

>>> rtl/rsc_ram.sv
module rsc_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/rsc_acc.sv
module rsc_acc (
    input  logic                              clk,
    input  logic                              rst_n,
    input  rsc_pkg::acc_cmd_t                 cmd,
    input  logic [rsc_pkg::BASE_W-1:0]        base,
    output rsc_pkg::acc_stat_t                stat,
    output logic [rsc_pkg::VALUE_W-1:0]       value
);

    logic [rsc_pkg::VALUE_W-1:0]   acc_reg, acc_next;
    logic [rsc_pkg::DIGIT_W-1:0]   carry_reg, carry_next;
    logic [rsc_pkg::NIB_CNT_W-1:0] cnt_reg, cnt_next;
    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic                          ovf_reg, ovf_next;
    logic [8:0]                    prod;

    // One nibble of the accumulator is multiplied by the base per cycle; the
    // register rotates right so the full word is back in place after all nibbles.
    assign prod = {5'd0, acc_reg[rsc_pkg::DIGIT_W-1:0]} * {4'd0, base}
                  + {5'd0, carry_reg};

    always_comb
    begin
        acc_next   = acc_reg;
        carry_next = carry_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        ovf_next   = ovf_reg;
        if (cmd.clear)
        begin
            acc_next = '0;
        end
        else if (cmd.start)
        begin
            busy_next  = 1'b1;
            carry_next = cmd.digit;
            cnt_next   = '0;
        end
        else if (busy_reg)
        begin
            acc_next   = {prod[rsc_pkg::DIGIT_W-1:0],
                          acc_reg[rsc_pkg::VALUE_W-1:rsc_pkg::DIGIT_W]};
            carry_next = prod[7:4];
            cnt_next   = cnt_reg + rsc_pkg::NIB_CNT_W'(1);
            if (cnt_reg == rsc_pkg::NIB_CNT_W'(rsc_pkg::NIBBLES - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                ovf_next  = (prod[7:4] != '0);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= '0;
            carry_reg <= '0;
            cnt_reg   <= '0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            acc_reg   <= acc_next;
            carry_reg <= carry_next;
            cnt_reg   <= cnt_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            ovf_reg   <= ovf_next;
        end
    end

    assign stat.done = done_reg;
    assign stat.ovf  = ovf_reg;
    assign value     = acc_reg;

endmodule

>>> rtl/rsc_div.sv
module rsc_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  rsc_pkg::div_cmd_t                 cmd,
    input  logic [rsc_pkg::VALUE_W-1:0]       value,
    input  logic [rsc_pkg::BASE_W-1:0]        base,
    output rsc_pkg::div_stat_t                stat
);

    logic [rsc_pkg::VALUE_W-1:0]   q_reg, q_next;
    logic [rsc_pkg::DIGIT_W-1:0]   r_reg, r_next;
    logic [rsc_pkg::BIT_CNT_W-1:0] cnt_reg, cnt_next;
    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic                          nz_reg, nz_next;
    logic [rsc_pkg::BASE_W-1:0]    trial;
    logic [rsc_pkg::BASE_W-1:0]    diff;
    logic                          qbit;

    // Restoring long division, one dividend bit per cycle, most significant
    // first. Quotient bits shift into the dividend register from the bottom.
    assign trial = {r_reg, q_reg[rsc_pkg::VALUE_W-1]};
    assign qbit  = (trial >= base);
    assign diff  = trial - base;

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        nz_next   = nz_reg;
        if (cmd.start)
        begin
            if (cmd.reload)
            begin
                q_next = value;
            end
            r_next    = '0;
            cnt_next  = '0;
            nz_next   = 1'b0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            q_next   = {q_reg[rsc_pkg::VALUE_W-2:0], qbit};
            r_next   = qbit ? diff[rsc_pkg::DIGIT_W-1:0] : trial[rsc_pkg::DIGIT_W-1:0];
            nz_next  = nz_reg | qbit;
            cnt_next = cnt_reg + rsc_pkg::BIT_CNT_W'(1);
            if (cnt_reg == rsc_pkg::BIT_CNT_W'(rsc_pkg::VALUE_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg    <= '0;
            r_reg    <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            nz_reg   <= 1'b0;
        end
        else
        begin
            q_reg    <= q_next;
            r_reg    <= r_next;
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
            nz_reg   <= nz_next;
        end
    end

    assign stat.done    = done_reg;
    assign stat.nonzero = nz_reg;
    assign stat.rem     = r_reg;

endmodule

>>> rtl/radix_string_converter.sv
// Each character request is accepted in the idle state and then passed through the nibble-serial accumulator.
// A last character then starts the bit-serial divider, which yields one output digit per division,
// followed by the read, load and hold states for each digit emitted, where the output side may stall.
// One number is converted at a time; no character is taken until its digits are delivered.
// Reset (rst_n, asynchronous, active low) clears the value, the flags and all control state,
// and sets the input base to 10 and the output base to 16.
module radix_string_converter #(
    parameter int MAX_DIGITS = rsc_pkg::MAX_DIGITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            char_valid,
    output logic                            char_stall,
    input  rsc_pkg::char_req_t              char_req,
    output logic                            digit_valid,
    input  logic                            digit_stall,
    output rsc_pkg::digit_req_t             digit_req,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [rsc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rsc_pkg::BASE_W-1:0]      cfg_data
);

    localparam int AW    = $clog2(MAX_DIGITS);
    localparam int CNT_W = $clog2(MAX_DIGITS + 1);

    rsc_pkg::state_t               state_reg, state_next;
    logic [CNT_W-1:0]              count_reg, count_next;
    logic [CNT_W-1:0]              count_inc, count_dec;
    logic                          last_reg, last_next;
    logic                          ovf_reg, ovf_next;
    logic                          bad_reg, bad_next;
    logic                          out_valid_reg, out_valid_next;
    rsc_pkg::digit_req_t           out_reg, out_next;
    logic [rsc_pkg::BASE_W-1:0]    in_base_reg, out_base_reg;
    logic [rsc_pkg::BASE_W-1:0]    in_base_eff, out_base_eff;
    logic [4:0]                    char_val;
    rsc_pkg::acc_cmd_t             acc_cmd;
    rsc_pkg::acc_stat_t            acc_stat;
    rsc_pkg::div_cmd_t             div_cmd;
    rsc_pkg::div_stat_t            div_stat;
    logic [rsc_pkg::VALUE_W-1:0]   acc_value;
    logic                          ram_we;
    logic [rsc_pkg::DIGIT_W-1:0]   ram_rdata;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_base_reg  <= rsc_pkg::IN_BASE_RST;
            out_base_reg <= rsc_pkg::OUT_BASE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                rsc_pkg::REG_IN_BASE:  in_base_reg  <= cfg_data;
                rsc_pkg::REG_OUT_BASE: out_base_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign in_base_eff  = rsc_pkg::clamp_base(in_base_reg);
    assign out_base_eff = rsc_pkg::clamp_base(out_base_reg);
    assign char_val     = rsc_pkg::char_value(char_req.char_code);
    assign count_inc    = count_reg + CNT_W'(1);
    assign count_dec    = count_reg - CNT_W'(1);

    rsc_acc u_acc (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (acc_cmd),
        .base  (in_base_eff),
        .stat  (acc_stat),
        .value (acc_value)
    );

    rsc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (div_cmd),
        .value (acc_value),
        .base  (out_base_eff),
        .stat  (div_stat)
    );

    rsc_ram #(
        .WIDTH (rsc_pkg::DIGIT_W),
        .DEPTH (MAX_DIGITS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (div_stat.rem),
        .raddr (count_dec[AW-1:0]),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        last_next      = last_reg;
        ovf_next       = ovf_reg;
        bad_next       = bad_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        acc_cmd        = '0;
        div_cmd        = '0;
        ram_we         = 1'b0;
        unique case (state_reg)
            rsc_pkg::ST_IDLE:
            begin
                if (char_valid)
                begin
                    acc_cmd.start = 1'b1;
                    if (char_val == rsc_pkg::DIGIT_BAD)
                    begin
                        bad_next      = 1'b1;
                        acc_cmd.digit = '0;
                    end
                    else
                    begin
                        acc_cmd.digit = char_val[rsc_pkg::DIGIT_W-1:0];
                    end
                    last_next  = char_req.last_in;
                    state_next = rsc_pkg::ST_ACCUM;
                end
            end
            rsc_pkg::ST_ACCUM:
            begin
                if (acc_stat.done)
                begin
                    if (acc_stat.ovf)
                    begin
                        ovf_next = 1'b1;
                    end
                    if (last_reg)
                    begin
                        div_cmd.start  = 1'b1;
                        div_cmd.reload = 1'b1;
                        count_next     = '0;
                        state_next     = rsc_pkg::ST_DIVIDE;
                    end
                    else
                    begin
                        state_next = rsc_pkg::ST_IDLE;
                    end
                end
            end
            rsc_pkg::ST_DIVIDE:
            begin
                if (div_stat.done)
                begin
                    ram_we     = 1'b1;
                    count_next = count_inc;
                    if (div_stat.nonzero && (count_inc < CNT_W'(MAX_DIGITS)))
                    begin
                        div_cmd.start = 1'b1;
                    end
                    else
                    begin
                        state_next = rsc_pkg::ST_EMIT_RD;
                    end
                end
            end
            rsc_pkg::ST_EMIT_RD:
            begin
                state_next = rsc_pkg::ST_EMIT_LOAD;
            end
            rsc_pkg::ST_EMIT_LOAD:
            begin
                out_next.digit_char = rsc_pkg::digit_ascii(ram_rdata);
                out_next.last_out   = (count_reg == CNT_W'(1));
                out_next.overflow   = ovf_reg;
                out_next.bad_char   = bad_reg;
                out_valid_next      = 1'b1;
                state_next          = rsc_pkg::ST_EMIT_HOLD;
            end
            rsc_pkg::ST_EMIT_HOLD:
            begin
                if (!digit_stall)
                begin
                    out_valid_next = 1'b0;
                    count_next     = count_dec;
                    if (count_reg == CNT_W'(1))
                    begin
                        acc_cmd.clear = 1'b1;
                        ovf_next      = 1'b0;
                        bad_next      = 1'b0;
                        state_next    = rsc_pkg::ST_IDLE;
                    end
                    else
                    begin
                        state_next = rsc_pkg::ST_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = rsc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rsc_pkg::ST_IDLE;
            count_reg     <= '0;
            last_reg      <= 1'b0;
            ovf_reg       <= 1'b0;
            bad_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            last_reg      <= last_next;
            ovf_reg       <= ovf_next;
            bad_reg       <= bad_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign char_stall  = (state_reg != rsc_pkg::ST_IDLE);
    assign digit_valid = out_valid_reg;
    assign digit_req   = out_reg;

    a_digit_has_count: assert property (@(posedge clk) disable iff (!rst_n)
        digit_valid |-> (count_reg != '0))
        else $error("digit request with empty digit store");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_DIGITS))
        else $error("digit count beyond store depth");

    a_last_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
        (digit_valid && !digit_stall && digit_req.last_out) |=> !char_stall)
        else $error("input not reopened after final digit");

    a_acc_done_in_accum: assert property (@(posedge clk) disable iff (!rst_n)
        acc_stat.done |-> (state_reg == rsc_pkg::ST_ACCUM))
        else $error("accumulator finished outside accumulate state");

    a_div_done_in_divide: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == rsc_pkg::ST_DIVIDE))
        else $error("divider finished outside divide state");

endmodule
